// ----- hw/rtl/srt_pkg.sv -----
// shared types, constants and control structs for the sorted record table
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 7;
    localparam int KEY_W       = 32;
    localparam int SAL_W       = 32;
    localparam int TEXT_W      = 64;
    localparam int REC_W       = KEY_W + SAL_W + 3 * TEXT_W;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [SAL_W-1:0] salary;
        logic [TEXT_W-1:0]       first;
        logic [TEXT_W-1:0]       last;
        logic [TEXT_W-1:0]       dept;
    } record_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_ENTRY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_RD,
        S_INS_WR,
        S_INS_NEW,
        S_DEL_RD,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RES_DONE,
        S_RES_FULL,
        S_RES_MISS
    } state_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_new;
        logic    mark_pos;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    fill_inc;
        logic    fill_dec;
        logic    out_load;
        status_t out_code;
    } ctrl_cmd_t;

    typedef struct packed {
        req_type_t req;
        logic      full;
        logic      empty;
        logic      ptr_at_fill;
        logic      ptr_at_pos;
        logic      ptr_next_last;
        logic      key_less;
        logic      key_eq;
        logic      out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/sorted_record_table.sv -----
// top level of the sorted record table: controller plus datapath
// insert: search reads and compares stored keys in turn, then shifts later entries up with
// a read and a write each, then writes the new record; delete: search, then shift down
// dump: read then output per entry; set by the single-port record memory with registered read
// one request in flight at a time; a new request is taken while the last result still waits
// reset (rst_n, async, active low) empties the table at once; no clearing pass is needed
module sorted_record_table import srt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [KEY_W-1:0] rec_key,
    input  logic signed [SAL_W-1:0] rec_salary,
    input  logic [TEXT_W-1:0]       rec_first,
    input  logic [TEXT_W-1:0]       rec_last,
    input  logic [TEXT_W-1:0]       rec_dept,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] out_key,
    output logic signed [SAL_W-1:0] out_salary,
    output logic [TEXT_W-1:0]       out_first,
    output logic [TEXT_W-1:0]       out_last,
    output logic [TEXT_W-1:0]       out_dept,
    output logic [COUNT_W-1:0]      entry_count,
    output logic                    last_of_run
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .rec_key     (rec_key),
        .rec_salary  (rec_salary),
        .rec_first   (rec_first),
        .rec_last    (rec_last),
        .rec_dept    (rec_dept),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_key     (out_key),
        .out_salary  (out_salary),
        .out_first   (out_first),
        .out_last    (out_last),
        .out_dept    (out_dept),
        .entry_count (entry_count),
        .last_of_run (last_of_run)
    );

endmodule

// ----- hw/rtl/srt_ram.sv -----
// generic single write port, single read port ram with registered read
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/srt_ctrl.sv -----
// controller state machine sequencing search, shift, dump and result steps
module srt_ctrl import srt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_insert;

    assign is_insert = (stat.req == REQ_INSERT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req)
                    REQ_INSERT: state_next = stat.full ? S_RES_FULL : S_SRCH_RD;
                    REQ_DELETE: state_next = S_SRCH_RD;
                    REQ_DUMP:   state_next = stat.empty ? S_RES_DONE : S_DUMP_RD;
                    default:    state_next = S_RES_DONE;
                endcase
            end
            S_SRCH_RD:
            begin
                if (stat.ptr_at_fill)
                begin
                    state_next = is_insert ? S_INS_RD : S_RES_MISS;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.key_less)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (is_insert)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = stat.key_eq ? S_DEL_RD : S_RES_MISS;
                end
            end
            S_INS_RD:   state_next = stat.ptr_at_pos ? S_INS_NEW : S_INS_WR;
            S_INS_WR:   state_next = S_INS_RD;
            S_INS_NEW:  state_next = S_RES_DONE;
            S_DEL_RD:   state_next = stat.ptr_next_last ? S_RES_DONE : S_DEL_WR;
            S_DEL_WR:   state_next = S_DEL_RD;
            S_DUMP_RD:  state_next = S_DUMP_OUT;
            S_DUMP_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.ptr_next_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RES_DONE, S_RES_FULL, S_RES_MISS:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = RD_PTR;
        cmd.out_code = ST_DONE;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_SRCH_RD:
            begin
                if (stat.ptr_at_fill)
                begin
                    cmd.mark_pos = is_insert;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.key_less)
                begin
                    cmd.ptr_inc = 1'b1;
                end
                else
                begin
                    cmd.mark_pos = is_insert;
                end
            end
            S_INS_RD:
            begin
                if (!stat.ptr_at_pos)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_dec = 1'b1;
            end
            S_INS_NEW:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_new   = 1'b1;
                cmd.fill_inc = 1'b1;
            end
            S_DEL_RD:
            begin
                if (stat.ptr_next_last)
                begin
                    cmd.fill_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            S_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PTR;
            end
            S_DUMP_OUT:
            begin
                cmd.out_code = ST_ENTRY;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.ptr_inc  = !stat.ptr_next_last;
                end
            end
            S_RES_DONE:
            begin
                cmd.out_code = ST_DONE;
                cmd.out_load = stat.out_free;
            end
            S_RES_FULL:
            begin
                cmd.out_code = ST_FULL;
                cmd.out_load = stat.out_free;
            end
            S_RES_MISS:
            begin
                cmd.out_code = ST_MISSING;
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.out_code = ST_DONE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/srt_dp.sv -----
// datapath: request latch, pointers, fill count, record memory and output register
module srt_dp import srt_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                stat,
    input  logic [1:0]                req_type,
    input  logic signed [KEY_W-1:0]   rec_key,
    input  logic signed [SAL_W-1:0]   rec_salary,
    input  logic [TEXT_W-1:0]         rec_first,
    input  logic [TEXT_W-1:0]         rec_last,
    input  logic [TEXT_W-1:0]         rec_dept,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [KEY_W-1:0]   out_key,
    output logic signed [SAL_W-1:0]   out_salary,
    output logic [TEXT_W-1:0]         out_first,
    output logic [TEXT_W-1:0]         out_last,
    output logic [TEXT_W-1:0]         out_dept,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      last_of_run
);

    req_type_t          req_reg;
    record_t            rec_reg;
    logic [COUNT_W-1:0] ptr_reg;
    logic [COUNT_W-1:0] ptr_next;
    logic [COUNT_W-1:0] pos_reg;
    logic [COUNT_W-1:0] pos_next;
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fill_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    record_t            out_rec_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    logic [COUNT_W-1:0] ptr_plus;
    logic [COUNT_W-1:0] ptr_minus;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    record_t            wr_rec;
    logic [REC_W-1:0]   rd_data;
    record_t            rd_rec;

    assign ptr_plus  = ptr_reg + COUNT_W'(1);
    assign ptr_minus = ptr_reg - COUNT_W'(1);
    assign rd_rec    = rd_data;
    assign wr_addr   = ptr_reg[IDX_W-1:0];
    assign wr_rec    = cmd.wr_new ? rec_reg : rd_rec;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PTR:  rd_addr = ptr_reg[IDX_W-1:0];
            RD_PREV: rd_addr = ptr_minus[IDX_W-1:0];
            RD_NEXT: rd_addr = ptr_plus[IDX_W-1:0];
            default: rd_addr = ptr_reg[IDX_W-1:0];
        endcase
    end

    srt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load_req)
        begin
            ptr_next = '0;
        end
        else if (cmd.mark_pos)
        begin
            ptr_next = fill_reg;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_plus;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_minus;
        end

        pos_next = cmd.mark_pos ? ptr_reg : pos_reg;

        fill_next = fill_reg;
        if (cmd.fill_inc)
        begin
            fill_next = fill_reg + COUNT_W'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - COUNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg        <= req_type_t'(req_type);
            rec_reg.key    <= rec_key;
            rec_reg.salary <= rec_salary;
            rec_reg.first  <= rec_first;
            rec_reg.last   <= rec_last;
            rec_reg.dept   <= rec_dept;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_code;
            out_count_reg  <= fill_reg;
            if (cmd.out_code == ST_ENTRY)
            begin
                out_rec_reg  <= rd_rec;
                out_last_reg <= stat.ptr_next_last;
            end
            else
            begin
                out_rec_reg  <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign stat.req           = req_reg;
    assign stat.full          = (fill_reg == COUNT_W'(TABLE_DEPTH));
    assign stat.empty         = (fill_reg == '0);
    assign stat.ptr_at_fill   = (ptr_reg == fill_reg);
    assign stat.ptr_at_pos    = (ptr_reg == pos_reg);
    assign stat.ptr_next_last = (ptr_plus == fill_reg);
    assign stat.key_less      = (rd_rec.key < rec_reg.key);
    assign stat.key_eq        = (rd_rec.key == rec_reg.key);
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign out_key     = out_rec_reg.key;
    assign out_salary  = out_rec_reg.salary;
    assign out_first   = out_rec_reg.first;
    assign out_last    = out_rec_reg.last;
    assign out_dept    = out_rec_reg.dept;
    assign entry_count = out_count_reg;
    assign last_of_run = out_last_reg;

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_inc |-> !stat.full)
        else $error("insert committed into a full table");

    a_no_overwrite_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("read and write to record memory in one cycle");

    a_fill_moves_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_inc |=> fill_reg == $past(fill_reg) + COUNT_W'(1))
        else $error("fill count did not advance after insert");
`endif

endmodule

// ----- dv/sorted_record_table_tb.sv -----
// self-checking testbench for the sorted record table: directed rows, then random requests
module tb;
    import srt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 160;

    typedef struct {
        status_t            code;
        record_t            rec;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    typedef struct {
        logic [1:0]              req;
        logic signed [KEY_W-1:0] key;
        logic signed [SAL_W-1:0] salary;
        logic [TEXT_W-1:0]       text;
        bit                      has_want;
        status_t                 code;
        int                      count;
    } step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type = '0;
    logic signed [KEY_W-1:0] rec_key = '0;
    logic signed [SAL_W-1:0] rec_salary = '0;
    logic [TEXT_W-1:0]       rec_first = '0;
    logic [TEXT_W-1:0]       rec_last = '0;
    logic [TEXT_W-1:0]       rec_dept = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [SAL_W-1:0] out_salary;
    logic [TEXT_W-1:0]       out_first;
    logic [TEXT_W-1:0]       out_last;
    logic [TEXT_W-1:0]       out_dept;
    logic [COUNT_W-1:0]      entry_count;
    logic                    last_of_run;

    record_t shadow_rec [TABLE_DEPTH];
    int      shadow_fill = 0;
    result_t pending_results [$];
    int      mismatch_count = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      stall_cycles = 0;
    bit      growing = 1'b1;

    int send_idle_pct [3] = '{17, 70, 0};
    int recv_idle_pct [3] = '{70, 17, 0};

    step_t directed_steps [18] = '{
        '{REQ_DUMP,   0,              0,              64'h0,                 1'b1, ST_DONE,    0},
        '{REQ_DELETE, 0,              0,              64'h0,                 1'b1, ST_MISSING, 0},
        '{REQ_UNUSED, 0,              0,              64'h0,                 1'b1, ST_DONE,    0},
        '{REQ_INSERT, 32'sh7fffffff,  32'sh80000000,  64'hffffffffffffffff,  1'b1, ST_DONE,    1},
        '{REQ_INSERT, 32'sh80000000,  32'sh7fffffff,  64'h0,                 1'b1, ST_DONE,    2},
        '{REQ_INSERT, 0,              100,            64'h0123456789abcdef,  1'b0, ST_DONE,    0},
        '{REQ_INSERT, 0,              200,            64'hfedcba9876543210,  1'b0, ST_DONE,    0},
        '{REQ_INSERT, -1,             -1,             64'h5555555555555555,  1'b0, ST_DONE,    0},
        '{REQ_INSERT, 0,              300,            64'haaaaaaaaaaaaaaaa,  1'b0, ST_DONE,    0},
        '{REQ_DUMP,   0,              0,              64'h0,                 1'b0, ST_DONE,    0},
        '{REQ_DELETE, 5,              0,              64'h0,                 1'b1, ST_MISSING, 6},
        '{REQ_DELETE, 32'sh7fffffff,  0,              64'h0,                 1'b1, ST_DONE,    5},
        '{REQ_DELETE, 32'sh7ffffffe,  0,              64'h0,                 1'b1, ST_MISSING, 5},
        '{REQ_DELETE, 0,              0,              64'h0,                 1'b0, ST_DONE,    0},
        '{REQ_DUMP,   0,              0,              64'h0,                 1'b0, ST_DONE,    0},
        '{REQ_UNUSED, 0,              0,              64'h0,                 1'b1, ST_DONE,    4},
        '{REQ_DELETE, 32'sh80000000,  0,              64'h0,                 1'b1, ST_DONE,    3},
        '{REQ_DUMP,   0,              0,              64'h0,                 1'b0, ST_DONE,    0}
    };

    sorted_record_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .rec_key     (rec_key),
        .rec_salary  (rec_salary),
        .rec_first   (rec_first),
        .rec_last    (rec_last),
        .rec_dept    (rec_dept),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_key     (out_key),
        .out_salary  (out_salary),
        .out_first   (out_first),
        .out_last    (out_last),
        .out_dept    (out_dept),
        .entry_count (entry_count),
        .last_of_run (last_of_run)
    );

    always #4 clk = ~clk;

    function automatic int find_slot(logic signed [KEY_W-1:0] k);
        int p = 0;
        while (p < shadow_fill && shadow_rec[p].key < k)
            p++;
        return p;
    endfunction

    // update the shadow table and queue the results one request causes
    function automatic void apply_request(logic [1:0] req, record_t rec);
        int      pos;
        result_t res;
        res.code = ST_DONE;
        res.rec  = '0;
        res.last = 1'b1;
        case (req)
            REQ_INSERT:
            begin
                if (shadow_fill >= TABLE_DEPTH)
                    res.code = ST_FULL;
                else
                begin
                    pos = find_slot(rec.key);
                    for (int i = shadow_fill; i > pos; i--)
                        shadow_rec[i] = shadow_rec[i-1];
                    shadow_rec[pos] = rec;
                    shadow_fill++;
                end
            end
            REQ_DELETE:
            begin
                pos = find_slot(rec.key);
                if (pos >= shadow_fill || shadow_rec[pos].key != rec.key)
                    res.code = ST_MISSING;
                else
                begin
                    for (int i = pos; i + 1 < shadow_fill; i++)
                        shadow_rec[i] = shadow_rec[i+1];
                    shadow_fill--;
                end
            end
            REQ_DUMP:
            begin
                if (shadow_fill > 0)
                begin
                    for (int i = 0; i < shadow_fill; i++)
                    begin
                        res.code  = ST_ENTRY;
                        res.rec   = shadow_rec[i];
                        res.count = COUNT_W'(shadow_fill);
                        res.last  = (i + 1 == shadow_fill);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(shadow_fill);
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 50)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic send_request(logic [1:0] req, record_t rec);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        rec_key    <= rec.key;
        rec_salary <= rec.salary;
        rec_first  <= rec.first;
        rec_last   <= rec.last;
        rec_dept   <= rec.dept;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_request(req, rec);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $signed($urandom_range(24)) - 12;
        else if (roll < 90)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return -1;
            default: return 0;
        endcase
    endfunction

    task automatic send_random();
        int         roll;
        logic [1:0] req;
        record_t    rec;
        roll       = $urandom_range(99);
        rec.key    = pick_key();
        rec.salary = $urandom;
        rec.first  = {$urandom, $urandom};
        rec.last   = {$urandom, $urandom};
        rec.dept   = {$urandom, $urandom};
        if (growing)
            req = roll < 80 ? REQ_INSERT : roll < 88 ? REQ_DELETE : roll < 97 ? REQ_DUMP
                : REQ_UNUSED;
        else
            req = roll < 75 ? REQ_DELETE : roll < 85 ? REQ_INSERT : roll < 96 ? REQ_DUMP
                : REQ_UNUSED;
        // most deletes aim at a stored key
        if (req == REQ_DELETE && shadow_fill > 0 && $urandom_range(99) < 70)
            rec.key = shadow_rec[$urandom_range(shadow_fill - 1)].key;
        send_request(req, rec);
        if (growing && shadow_fill == TABLE_DEPTH && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (!growing && shadow_fill == 0)
            growing = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d key %0d",
                                          status, out_key));
            else
            begin
                want = pending_results.pop_front();
                check_field("status", status, want.code);
                check_field("out_key", out_key, want.rec.key);
                check_field("out_salary", out_salary, want.rec.salary);
                check_field("out_first", out_first, want.rec.first);
                check_field("out_last", out_last, want.rec.last);
                check_field("out_dept", out_dept, want.rec.dept);
                check_field("entry_count", entry_count, want.count);
                check_field("last_of_run", last_of_run, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        record_t rec;
        result_t fixed_res;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = send_idle_pct[ph];
            recv_idle = recv_idle_pct[ph];
            if (ph == 0)
            begin
                foreach (directed_steps[i])
                begin
                    rec.key    = directed_steps[i].key;
                    rec.salary = directed_steps[i].salary;
                    rec.first  = directed_steps[i].text;
                    rec.last   = ~directed_steps[i].text;
                    rec.dept   = {directed_steps[i].text[31:0], directed_steps[i].text[63:32]};
                    send_request(directed_steps[i].req, rec);
                    if (directed_steps[i].has_want)
                    begin
                        void'(pending_results.pop_back());
                        fixed_res.code  = directed_steps[i].code;
                        fixed_res.rec   = '0;
                        fixed_res.count = COUNT_W'(directed_steps[i].count);
                        fixed_res.last  = 1'b1;
                        pending_results.push_back(fixed_res);
                    end
                end
            end
            repeat (RANDOM_PER_PHASE) send_random();
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
